FILE: rtl/core/leader_point_clustering_macros.svh
// Assertion macros used by the checker file.
`ifndef LEADER_POINT_CLUSTERING_MACROS_SVH
`define LEADER_POINT_CLUSTERING_MACROS_SVH

// Implication checked on every clock, masked while reset is low.
`define LPC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: label failed");

// Next-cycle implication, masked while reset is low.
`define LPC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: label failed");

`endif

FILE: rtl/core/lpc_pkg.sv
package lpc_pkg;
  localparam int unsigned MaxClustersDefault = 16;
  localparam int unsigned CoordW = 16;
  localparam int unsigned CountW = 16;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned InDataW = 32;
  localparam int unsigned OutDataW = 56;
  localparam int unsigned OutUserW = 2;

  localparam logic [CfgIdxW-1:0] RegJoinTol = 2'd0;
  localparam logic [CfgIdxW-1:0] RegMinPts = 2'd1;
  localparam logic [CfgIdxW-1:0] RegMaxRange = 2'd2;

  localparam logic [15:0] JoinTolReset = 16'd128;
  localparam logic [15:0] MinPtsReset = 16'd1;
  localparam logic [15:0] MaxRangeReset = 16'd2560;
endpackage

FILE: rtl/core/leader_point_clustering.sv
// Channel | Dir | Fields (tdata low->high)                 | tuser
// in_     | in  | point_x, point_y                         | last_point on tlast
// out_    | out | centre_x, centre_y, member_count, entry_valid, table_overflowed
//         |     |                                          | final_entry on tlast
// cfg_    | in  | we, idx, data                            | -
// A point passes an accept state, a read and a compare state per stored cluster, the
// shared serial divider once per axis when it joins, and a write-back state; an empty
// table skips to write-back. A last point then walks every stored cluster (read, square,
// check), reports each that qualifies and ends with the closing transfer, held by back-pressure.
// rst_n is synchronous; the tables hold no reset and are read only below the fill count.
// The output register frees the walk when it is empty or the downstream side takes the result.
module leader_point_clustering #(
  parameter int unsigned MAX_CLUSTERS = lpc_pkg::MaxClustersDefault
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [lpc_pkg::InDataW-1:0]   in_tdata,   // point_x, point_y
  input  logic                          in_tlast,   // last_point
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [lpc_pkg::OutDataW-1:0]  out_tdata,  // centre_x, centre_y, member_count,
                                                    // entry_valid, table_overflowed, pad
  output logic                          out_tlast,  // final_entry
  input  logic                          cfg_we,
  input  logic [lpc_pkg::CfgIdxW-1:0]   cfg_idx,
  input  logic [lpc_pkg::CfgDataW-1:0]  cfg_data
);
  localparam int unsigned AW = $clog2(MAX_CLUSTERS);
  localparam int unsigned NW = $clog2(MAX_CLUSTERS + 1);
  localparam int unsigned EW = 2 * lpc_pkg::CoordW + lpc_pkg::CountW;

  typedef enum logic [3:0] {
    S_IDLE, S_RD, S_CMP, S_DIVX, S_WAITX, S_DIVY, S_WAITY, S_WB,
    S_RPT_RD, S_RPT_SQ, S_RPT_CHK, S_RPT_OUT, S_EMPTY
  } state_t;

  state_t              state_r;
  logic [14:0]         tol_r;
  logic [15:0]         min_r;
  logic [15:0]         rng_r;
  logic [NW-1:0]       used_r;
  logic                ovf_r;
  logic signed [15:0]  px_r, py_r;
  logic                last_r;
  logic [NW-1:0]       idx_r;
  logic [33:0]         best_r;
  logic                found_r;
  logic [AW-1:0]       sel_r;
  logic signed [15:0]  sx_r, sy_r;
  logic [15:0]         sc_r;
  logic signed [15:0]  nx_r;
  logic [33:0]         d2_r;
  logic [2*lpc_pkg::CoordW+lpc_pkg::CountW+3-1:0] pend_r;
  logic                pend_v_r;
  logic                otv_r;
  logic [lpc_pkg::OutDataW-1:0] otd_r;
  logic                otl_r;

  logic                we;
  logic [AW-1:0]       waddr, raddr;
  logic [EW-1:0]       wdata, rdata;
  logic signed [15:0]  rx, ry;
  logic [15:0]         rc;
  logic signed [16:0]  dx, dy;
  logic signed [32:0]  mx, my;
  logic [33:0]         dsum;
  logic                div_start, div_busy;
  logic signed [32:0]  div_num;
  logic signed [15:0]  div_q;
  logic [16:0]         den;
  logic [15:0]         cnt_inc;
  logic [29:0]         tol_sq;
  logic [31:0]         rng_sq;
  logic                out_load;

  assign rx = rdata[15:0];
  assign ry = rdata[31:16];
  assign rc = rdata[47:32];
  assign raddr = idx_r[AW-1:0];

  lpc_ram #(.Width(EW), .Depth(MAX_CLUSTERS)) u_tab (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  assign den = {1'b0, sc_r} + 17'd1;
  assign cnt_inc = (sc_r == 16'hFFFF) ? sc_r : sc_r + 16'd1;
  assign tol_sq = tol_r * tol_r;
  assign rng_sq = rng_r * rng_r;

  always_comb begin
    div_start = 1'b0;
    div_num = 33'sd0;
    if (state_r == S_DIVX) begin
      div_start = 1'b1;
      div_num = sx_r * $signed({1'b0, sc_r}) + px_r;
    end else if (state_r == S_DIVY) begin
      div_start = 1'b1;
      div_num = sy_r * $signed({1'b0, sc_r}) + py_r;
    end
  end

  lpc_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(div_num), .den(den),
    .busy(div_busy), .quo(div_q)
  );

  always_comb begin
    dx = (state_r == S_RPT_SQ) ? {rx[15], rx} : ({px_r[15], px_r} - {rx[15], rx});
    dy = (state_r == S_RPT_SQ) ? {ry[15], ry} : ({py_r[15], py_r} - {ry[15], ry});
    mx = dx * dx;
    my = dy * dy;
    dsum = {1'b0, mx} + {1'b0, my};
  end

  always_comb begin
    we = 1'b0;
    waddr = sel_r;
    wdata = {cnt_inc, div_q, nx_r};
    if (state_r == S_WB) begin
      // a point that finds no room is dropped
      if (found_r || used_r != NW'(MAX_CLUSTERS)) begin
        we = 1'b1;
      end
      if (!found_r) begin
        waddr = used_r[AW-1:0];
        wdata = {16'd1, py_r, px_r};
      end
    end
  end

  always_comb begin
    out_load = 1'b0;
    if ((state_r == S_RPT_OUT && pend_v_r) || state_r == S_EMPTY) begin
      out_load = !otv_r || out_tready;
    end
  end

  assign in_tready = (state_r == S_IDLE);
  assign out_tvalid = otv_r;
  assign out_tdata = otd_r;
  assign out_tlast = otl_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      tol_r    <= lpc_pkg::JoinTolReset[14:0];
      min_r    <= lpc_pkg::MinPtsReset;
      rng_r    <= lpc_pkg::MaxRangeReset;
      used_r   <= '0;
      ovf_r    <= 1'b0;
      otv_r    <= 1'b0;
      pend_v_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          lpc_pkg::RegJoinTol:  tol_r <= cfg_data[14:0];
          lpc_pkg::RegMinPts:   min_r <= cfg_data;
          lpc_pkg::RegMaxRange: rng_r <= cfg_data;
          default: ;
        endcase
      end
      if (out_load) begin
        otv_r <= 1'b1;
      end else if (otv_r && out_tready) begin
        otv_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            px_r    <= in_tdata[15:0];
            py_r    <= in_tdata[31:16];
            last_r  <= in_tlast;
            idx_r   <= '0;
            best_r  <= {4'd0, tol_sq};
            found_r <= 1'b0;
            state_r <= (used_r == '0) ? S_WB : S_RD;
          end
        end
        S_RD: state_r <= S_CMP;
        S_CMP: begin
          if (dsum <= best_r) begin
            best_r  <= dsum;
            sel_r   <= idx_r[AW-1:0];
            found_r <= 1'b1;
            sx_r    <= rx;
            sy_r    <= ry;
            sc_r    <= rc;
          end
          if (idx_r + 1'b1 == used_r) begin
            idx_r   <= '0;
            state_r <= S_DIVX;
          end else begin
            idx_r   <= idx_r + 1'b1;
            state_r <= S_RD;
          end
        end
        S_DIVX: state_r <= found_r ? S_WAITX : S_WB;
        S_WAITX: begin
          if (!div_busy) begin
            nx_r    <= div_q;
            state_r <= S_DIVY;
          end
        end
        S_DIVY: state_r <= S_WAITY;
        S_WAITY: if (!div_busy) state_r <= S_WB;
        S_WB: begin
          if (!found_r) begin
            if (used_r == NW'(MAX_CLUSTERS)) begin
              ovf_r <= 1'b1;
            end else begin
              used_r <= used_r + 1'b1;
            end
          end
          idx_r    <= '0;
          pend_v_r <= 1'b0;
          if (!last_r) begin
            state_r <= S_IDLE;
          end else if (!found_r && used_r == NW'(MAX_CLUSTERS)) begin
            state_r <= S_RPT_RD;
          end else if (!found_r) begin
            state_r <= S_RPT_RD;
          end else begin
            state_r <= S_RPT_RD;
          end
        end
        S_RPT_RD: begin
          if (idx_r == used_r) begin
            state_r <= S_EMPTY;
          end else begin
            state_r <= S_RPT_SQ;
          end
        end
        S_RPT_SQ: begin
          d2_r    <= dsum;
          sx_r    <= rx;
          sy_r    <= ry;
          sc_r    <= rc;
          state_r <= S_RPT_CHK;
        end
        S_RPT_CHK: begin
          if (sc_r >= min_r && d2_r <= {2'd0, rng_sq}) begin
            state_r <= S_RPT_OUT;
          end else begin
            idx_r   <= idx_r + 1'b1;
            state_r <= S_RPT_RD;
          end
        end
        S_RPT_OUT: begin
          if (!pend_v_r) begin
            pend_r   <= {1'b0, ovf_r, 1'b1, sc_r, sy_r, sx_r};
            pend_v_r <= 1'b1;
            idx_r    <= idx_r + 1'b1;
            state_r  <= S_RPT_RD;
          end else if (out_load) begin
            otd_r    <= {5'd0, pend_r[50:0]};
            otl_r    <= 1'b0;
            pend_v_r <= 1'b0;
          end
        end
        S_EMPTY: begin
          if (out_load) begin
            otl_r   <= 1'b1;
            otd_r   <= pend_v_r ? {5'd0, pend_r[50:0]} :
                       {5'd0, 1'b0, ovf_r, 1'b0, 48'd0};
            used_r  <= '0;
            ovf_r   <= 1'b0;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

FILE: rtl/core/lpc_ram.sv
module lpc_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: rtl/core/lpc_div.sv
// Signed restoring divider: quotient of num / den truncated toward zero.
// num is 33-bit signed, den 17-bit positive. One quotient bit per cycle.
module lpc_div (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [32:0] num,
  input  logic        [16:0] den,
  output logic               busy,
  output logic signed [15:0] quo
);
  logic [32:0] mag_r, mag_nxt;
  logic [16:0] rem_r, rem_nxt;
  logic [16:0] den_r;
  logic        neg_r;
  logic [5:0]  cnt_r;
  logic [17:0] trial;
  logic [32:0] qmag;

  assign busy = (cnt_r != 6'd0);
  assign trial = {rem_r, mag_r[32]} - {1'b0, den_r};
  assign qmag = neg_r ? (33'd0 - mag_r) : mag_r;
  assign quo = qmag[15:0];

  always_comb begin
    rem_nxt = rem_r;
    mag_nxt = mag_r;
    if (!trial[17]) begin
      rem_nxt = trial[16:0];
      mag_nxt = {mag_r[31:0], 1'b1};
    end else begin
      rem_nxt = {rem_r[15:0], mag_r[32]};
      mag_nxt = {mag_r[31:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 6'd0;
    end else if (start) begin
      cnt_r <= 6'd33;
    end else if (busy) begin
      cnt_r <= cnt_r - 6'd1;
    end
    if (start) begin
      mag_r <= num[32] ? (33'd0 - num) : num;
      neg_r <= num[32];
      rem_r <= 17'd0;
      den_r <= den;
    end else if (busy) begin
      mag_r <= mag_nxt;
      rem_r <= rem_nxt;
    end
  end
endmodule

FILE: rtl/core/lpc_checker.sv
`include "leader_point_clustering_macros.svh"
module lpc_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_tvalid,
  input logic                          in_tready,
  input logic                          out_tvalid,
  input logic                          out_tready,
  input logic [lpc_pkg::OutDataW-1:0]  out_tdata,
  input logic                          out_tlast
);
  `LPC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  `LPC_ASSERT_IMPL(a_empty_last, clk, rst_n, out_tvalid && !out_tdata[48], out_tlast)
  `LPC_ASSERT_IMPL(a_no_take_busy, clk, rst_n, out_tvalid && !out_tlast, !in_tready)
  `LPC_ASSERT_IMPL(a_pad_zero, clk, rst_n, out_tvalid, out_tdata[55:51] == 5'd0)
  `LPC_ASSERT_NEXT(a_take_leaves_idle, clk, rst_n, in_tvalid && in_tready, !in_tready)
endmodule

bind leader_point_clustering lpc_checker u_lpc_checker (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
  .out_tlast(out_tlast)
);
